// ===== rtl/ssed_pkg.sv =====
// ----------------------------------------------------------------------------
// ssed_pkg
// Shared sizes, types and register codes of the scale-space extremum detector.
// ----------------------------------------------------------------------------
package ssed_pkg;

  // Volume limits
  localparam int MAX_SCALES = 16;
  localparam int MAX_ANGLES = 64;
  localparam int MAX_WIDTH  = 512;
  localparam int CFG_MIN    = 3;

  // Counter and bound widths
  localparam int SCALE_W = $clog2(MAX_SCALES);
  localparam int ANGLE_W = $clog2(MAX_ANGLES);
  localparam int POS_W   = $clog2(MAX_WIDTH);
  localparam int NS_W    = SCALE_W + 1;
  localparam int NA_W    = ANGLE_W + 1;
  localparam int NW_W    = POS_W + 1;

  // Plane memories: one per plane and angle parity, addressed {angle / 2, position}
  localparam int ROW_W     = ANGLE_W - 1;
  localparam int RAM_AW    = ROW_W + POS_W;
  localparam int RAM_DEPTH = 2 ** RAM_AW;

  // Word fields
  localparam int SAMPLE_W     = 32;
  localparam int ANGLE_IDX_W  = 6;
  localparam int SCALE_IDX_W  = 4;
  localparam int POS_IDX_W    = 9;
  localparam int IN_TDATA_W   = 32;
  localparam int OUT_FIELDS_W = ANGLE_IDX_W + SCALE_IDX_W + POS_IDX_W + SAMPLE_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Configuration port
  localparam int SCALE_CFG_W     = 5;
  localparam int ANGLE_CFG_W     = 7;
  localparam int WIDTH_CFG_W     = 10;
  localparam int CFG_DATA_W      = 10;
  localparam int CFG_IDX_W       = 2;
  localparam int SCALE_COUNT_RST = 16;
  localparam int ANGLE_COUNT_RST = 64;
  localparam int ROW_WIDTH_RST   = 512;

  // Neighbour count and result queue
  localparam int NB_COUNT    = 6;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE_COUNT = CFG_IDX_W'(0),
    REG_ANGLE_COUNT = CFG_IDX_W'(1),
    REG_ROW_WIDTH   = CFG_IDX_W'(2)
  } cfg_reg_e;

  // Access issued to the plane memories when a word is taken
  typedef struct packed {
    logic                       valid;
    logic                       prev_sel;
    logic [ANGLE_W-1:0]         angle;
    logic [POS_W-1:0]           pos;
    logic signed [SAMPLE_W-1:0] sample;
  } store_req_t;

  // Previous-plane neighbourhood and lower-scale neighbour, read in the cycle after the access
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] centre;
    logic signed [SAMPLE_W-1:0] north;
    logic signed [SAMPLE_W-1:0] south;
    logic signed [SAMPLE_W-1:0] east;
    logic signed [SAMPLE_W-1:0] lower;
  } nbhd_t;

  // Context of one sample travelling down the compare pipeline
  typedef struct packed {
    logic                       judge;
    logic [SCALE_W-1:0]         scale;
    logic [ANGLE_W-1:0]         angle;
    logic [POS_W-1:0]           pos;
    logic signed [SAMPLE_W-1:0] sample;
  } step_t;

  // Result word, last field in the lowest bits
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] peak_value;
    logic [POS_IDX_W-1:0]       position;
    logic [SCALE_IDX_W-1:0]     scale_index;
    logic [ANGLE_IDX_W-1:0]     angle_index;
  } result_t;

  typedef struct packed {
    logic s1_valid;
    logic s2_valid;
  } pipe_status_t;

endpackage

// ===== rtl/ssed_ram.sv =====
// ----------------------------------------------------------------------------
// ssed_ram
// Generic RAM: one write port, two read ports, registered read, read-first.
// ----------------------------------------------------------------------------
module ssed_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== rtl/ssed_plane_store.sv =====
// ----------------------------------------------------------------------------
// ssed_plane_store
// Two scale planes, each split by angle parity into two dual-read RAMs.
// ----------------------------------------------------------------------------
module ssed_plane_store (
  input  logic                 clk_i,
  input  ssed_pkg::store_req_t req_i,
  output ssed_pkg::nbhd_t      nbhd_o
);
  import ssed_pkg::*;

  logic [ROW_W-1:0]    row_c;
  logic [ROW_W-1:0]    row_n;
  logic [ROW_W-1:0]    row_s;
  logic [ANGLE_W-1:0]  angle_m1;
  logic [ANGLE_W-1:0]  angle_p1;
  logic [POS_W-1:0]    pos_p1;
  logic [RAM_AW-1:0]   addr_cc;
  logic [RAM_AW-1:0]   addr_ce;
  logic [RAM_AW-1:0]   addr_n;
  logic [RAM_AW-1:0]   addr_s;
  logic [SAMPLE_W-1:0] rd_a [2][2];
  logic [SAMPLE_W-1:0] rd_b [2][2];
  logic                prev_q;
  logic                par_q;

  // Rows a-1 and a+1 sit in the other parity RAM, row a in its own
  always_comb begin
    angle_m1 = req_i.angle - 1'b1;
    angle_p1 = req_i.angle + 1'b1;
    pos_p1   = req_i.pos + 1'b1;
    row_c    = req_i.angle[ANGLE_W-1:1];
    row_n    = angle_m1[ANGLE_W-1:1];
    row_s    = angle_p1[ANGLE_W-1:1];
    addr_cc  = {row_c, req_i.pos};
    addr_ce  = {row_c, pos_p1};
    addr_n   = {row_n, req_i.pos};
    addr_s   = {row_s, req_i.pos};
  end

  for (genvar b = 0; b < 2; b++) begin : g_plane
    for (genvar q = 0; q < 2; q++) begin : g_parity
      logic same;
      logic is_prev;

      assign same    = (1'(q) == req_i.angle[0]);
      assign is_prev = (1'(b) == req_i.prev_sel);

      // Older plane takes the new sample at its own address; read-first
      // returns the lower-scale neighbour from the same address
      ssed_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (RAM_DEPTH)
      ) u_ram (
        .clk_i     (clk_i),
        .we_i      (req_i.valid && !is_prev && same),
        .waddr_i   (addr_cc),
        .wdata_i   (req_i.sample),
        .raddr_a_i (same ? addr_cc : addr_n),
        .raddr_b_i (same ? addr_ce : addr_s),
        .rdata_a_o (rd_a[b][q]),
        .rdata_b_o (rd_b[b][q])
      );
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q <= req_i.prev_sel;
    par_q  <= req_i.angle[0];
  end

  always_comb begin
    nbhd_o.centre = rd_a[prev_q][par_q];
    nbhd_o.east   = rd_b[prev_q][par_q];
    nbhd_o.north  = rd_a[prev_q][!par_q];
    nbhd_o.south  = rd_b[prev_q][!par_q];
    nbhd_o.lower  = rd_a[!prev_q][par_q];
  end

endmodule

// ===== rtl/ssed_judge.sv =====
// ----------------------------------------------------------------------------
// ssed_judge
// Six-neighbour compare: flags in stage one, extremum decision in stage two.
// ----------------------------------------------------------------------------
module ssed_judge (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_valid_i,
  input  ssed_pkg::step_t        step_i,
  input  ssed_pkg::nbhd_t        nbhd_i,
  output ssed_pkg::pipe_status_t status_o,
  output logic                   res_valid_o,
  output ssed_pkg::result_t      res_o
);
  import ssed_pkg::*;

  logic                       s1_valid_q;
  step_t                      s1_step_q;
  logic signed [SAMPLE_W-1:0] west_q;
  logic signed [SAMPLE_W-1:0] centre;
  logic signed [SAMPLE_W-1:0] nb [NB_COUNT];
  logic [NB_COUNT-1:0]        le_d;
  logic [NB_COUNT-1:0]        ge_d;
  logic [NB_COUNT-1:0]        le_q;
  logic [NB_COUNT-1:0]        ge_q;
  logic                       s2_valid_q;
  logic                       s2_judge_q;
  result_t                    s2_res_d;
  result_t                    s2_res_q;

  always_comb begin
    centre = nbhd_i.centre;
    nb[0]  = nbhd_i.north;
    nb[1]  = nbhd_i.lower;
    nb[2]  = west_q;
    nb[3]  = nbhd_i.east;
    nb[4]  = s1_step_q.sample;
    nb[5]  = nbhd_i.south;
    for (int i = 0; i < NB_COUNT; i++) begin
      le_d[i] = (centre <= nb[i]);
      ge_d[i] = (centre >= nb[i]);
    end
    s2_res_d.angle_index = ANGLE_IDX_W'(s1_step_q.angle);
    s2_res_d.scale_index = SCALE_IDX_W'(s1_step_q.scale - 1'b1);
    s2_res_d.position    = POS_IDX_W'(s1_step_q.pos);
    s2_res_d.peak_value  = centre;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= step_valid_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  // The previous word's centre is this word's west neighbour: within a row
  // each position is always preceded by the one before it
  always_ff @(posedge clk_i) begin
    if (step_valid_i) begin
      s1_step_q <= step_i;
    end
    if (s1_valid_q) begin
      west_q     <= centre;
      le_q       <= le_d;
      ge_q       <= ge_d;
      s2_judge_q <= s1_step_q.judge;
      s2_res_q   <= s2_res_d;
    end
  end

  // A flat centre passes both tests and still yields one word
  assign res_valid_o       = s2_valid_q && s2_judge_q && ((&le_q) || (&ge_q));
  assign res_o             = s2_res_q;
  assign status_o.s1_valid = s1_valid_q;
  assign status_o.s2_valid = s2_valid_q;

endmodule

// ===== rtl/ssed_out_fifo.sv =====
// ----------------------------------------------------------------------------
// ssed_out_fifo
// Small result queue decoupling the compare pipeline from the output stream.
// ----------------------------------------------------------------------------
module ssed_out_fifo (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  ssed_pkg::result_t         push_data_i,
  input  logic                      pop_i,
  output logic                      valid_o,
  output ssed_pkg::result_t         data_o,
  output logic [ssed_pkg::FIFO_CNT_W-1:0] level_o
);
  import ssed_pkg::*;

  result_t               mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] count_q, count_d;

  function automatic logic [FIFO_PTR_W-1:0] ptr_inc(input logic [FIFO_PTR_W-1:0] ptr);
    logic [FIFO_PTR_W-1:0] nxt;
    if (ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) begin
      nxt = '0;
    end else begin
      nxt = ptr + 1'b1;
    end
    return nxt;
  endfunction

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + FIFO_CNT_W'(push_i) - FIFO_CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign level_o = count_q;

endmodule

// ===== rtl/scale_space_extremum_detector.sv =====
// ----------------------------------------------------------------------------
// scale_space_extremum_detector
// Streams a response volume (scale, then angle row, then position) and reports
// each interior sample that is a six-neighbour minimum or maximum.
//
//  channel   dir  word                                      handshake
//  s_axis    in   [31:0] sample_value                       tvalid/tready
//  m_axis    out  [5:0] angle_index, [9:6] scale_index,      tvalid/tready
//                 [18:10] position, [50:19] peak_value
//  cfg       in   index 0 scale_count, 1 angle_count,       cfg_we_i
//                 2 row_width
//
//  One input word per cycle sustained while input ready holds; the four plane
//  RAMs (two per plane, split by angle parity, two read ports each) serve the
//  centre and four neighbours; west and upper come from pipeline registers.
//  A result passes RAM read, compare and decision into the result queue.
//  Reset clears counters and plane select; plane RAMs are not cleared, and no
//  sample is judged while the first two planes of a volume stream in.
//  Input ready drops only while queue plus in-flight words fill the queue.
// ----------------------------------------------------------------------------
module scale_space_extremum_detector (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // sample_value [31:0]
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [ssed_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // angle_index [5:0], scale_index [9:6], position [18:10], peak_value [50:19]
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [ssed_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input  logic                                cfg_we_i,
  input  logic [ssed_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ssed_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);
  import ssed_pkg::*;

  // Bounds are held already clamped to their legal range
  logic [NS_W-1:0]    ns_q, ns_d;
  logic [NA_W-1:0]    na_q, na_d;
  logic [NW_W-1:0]    nw_q, nw_d;

  logic [SCALE_W-1:0] scale_q, scale_d;
  logic [ANGLE_W-1:0] angle_q, angle_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic               plane_sel_q, plane_sel_d;

  logic               accept;
  logic               pos_last;
  logic               angle_last;
  logic               scale_last;
  logic               interior;
  logic [FIFO_CNT_W:0] occupancy;

  store_req_t         store_req;
  nbhd_t              nbhd;
  step_t              step;
  pipe_status_t       status;
  logic               res_valid;
  result_t            res;
  logic               out_valid;
  result_t            out_data;
  logic [FIFO_CNT_W-1:0] fifo_level;

  function automatic int clamp_cfg(input int v, input int hi);
    int r;
    if (v < CFG_MIN) begin
      r = CFG_MIN;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // ---- configuration: take writes, drop unknown indexes ----
  always_comb begin
    ns_d = ns_q;
    na_d = na_q;
    nw_d = nw_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_SCALE_COUNT: begin
          ns_d = NS_W'(clamp_cfg(int'(cfg_wdata_i[SCALE_CFG_W-1:0]), MAX_SCALES));
        end
        REG_ANGLE_COUNT: begin
          na_d = NA_W'(clamp_cfg(int'(cfg_wdata_i[ANGLE_CFG_W-1:0]), MAX_ANGLES));
        end
        REG_ROW_WIDTH: begin
          nw_d = NW_W'(clamp_cfg(int'(cfg_wdata_i[WIDTH_CFG_W-1:0]), MAX_WIDTH));
        end
        default: begin
        end
      endcase
    end
  end

  // ---- input acceptance: hold off while the result queue could overflow ----
  always_comb begin
    occupancy = {1'b0, fifo_level} + (FIFO_CNT_W + 1)'(status.s1_valid)
              + (FIFO_CNT_W + 1)'(status.s2_valid);
  end

  assign s_axis_tready = (occupancy < (FIFO_CNT_W + 1)'(FIFO_DEPTH));
  assign accept        = s_axis_tvalid && s_axis_tready;

  // ---- volume counters: advance position, row, plane; swap planes per plane ----
  always_comb begin
    pos_last    = (({1'b0, pos_q} + 1'b1) >= nw_q);
    angle_last  = (({1'b0, angle_q} + 1'b1) >= na_q);
    scale_last  = (({1'b0, scale_q} + 1'b1) >= ns_q);
    scale_d     = scale_q;
    angle_d     = angle_q;
    pos_d       = pos_q;
    plane_sel_d = plane_sel_q;
    if (accept) begin
      if (pos_last) begin
        pos_d = '0;
        if (angle_last) begin
          angle_d     = '0;
          plane_sel_d = !plane_sel_q;
          scale_d     = scale_last ? '0 : scale_q + 1'b1;
        end else begin
          angle_d = angle_q + 1'b1;
        end
      end else begin
        pos_d = pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ns_q        <= NS_W'(clamp_cfg(SCALE_COUNT_RST, MAX_SCALES));
      na_q        <= NA_W'(clamp_cfg(ANGLE_COUNT_RST, MAX_ANGLES));
      nw_q        <= NW_W'(clamp_cfg(ROW_WIDTH_RST, MAX_WIDTH));
      scale_q     <= '0;
      angle_q     <= '0;
      pos_q       <= '0;
      plane_sel_q <= 1'b0;
    end else begin
      ns_q        <= ns_d;
      na_q        <= na_d;
      nw_q        <= nw_d;
      scale_q     <= scale_d;
      angle_q     <= angle_d;
      pos_q       <= pos_d;
      plane_sel_q <= plane_sel_d;
    end
  end

  // ---- judge the centre one plane back when its upper neighbour arrives ----
  // Interior: scale 2.. with centre plane below ns-1, angle 1..na-2, pos 1..nw-2
  always_comb begin
    interior = (scale_q >= SCALE_W'(2))
            && (({1'b0, scale_q} + 1'b1) <= ns_q)
            && (angle_q != '0)
            && (({1'b0, angle_q} + NA_W'(2)) <= na_q)
            && (pos_q != '0)
            && (({1'b0, pos_q} + NW_W'(2)) <= nw_q);
  end

  always_comb begin
    store_req.valid    = accept;
    store_req.prev_sel = plane_sel_q;
    store_req.angle    = angle_q;
    store_req.pos      = pos_q;
    store_req.sample   = s_axis_tdata[SAMPLE_W-1:0];
    step.judge         = interior;
    step.scale         = scale_q;
    step.angle         = angle_q;
    step.pos           = pos_q;
    step.sample        = s_axis_tdata[SAMPLE_W-1:0];
  end

  ssed_plane_store u_plane_store (
    .clk_i  (clk_i),
    .req_i  (store_req),
    .nbhd_o (nbhd)
  );

  ssed_judge u_judge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_valid_i (accept),
    .step_i       (step),
    .nbhd_i       (nbhd),
    .status_o     (status),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  // ---- result queue and output word ----
  ssed_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .pop_i       (m_axis_tvalid && m_axis_tready),
    .valid_o     (out_valid),
    .data_o      (out_data),
    .level_o     (fifo_level)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_TDATA_W'(out_data);

endmodule

// ===== rtl/ssed_checker.sv =====
// ----------------------------------------------------------------------------
// ssed_checker
// Port-level checks on the extremum detector, bound to its top level.
// ----------------------------------------------------------------------------
module ssed_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [ssed_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import ssed_pkg::*;

  result_t word;

  assign word = m_axis_tdata[$bits(result_t)-1:0];

  // No word leaves once reset has been seen at an edge
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("output word valid during reset");

  // A stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output word changed");

  // Only centres off the zero border of angle, scale and position are reported
  a_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (word.angle_index != '0) && (word.scale_index != '0)
                      && (word.position != '0))
    else $error("reported extremum on a volume border");

  // A word surfacing on an empty output was taken at the input, then passed RAM read, compare and queue
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 3))
    else $error("output word without matching input word");

  // Input back-pressure only while results wait
  a_ready_credit: assert property (@(posedge clk_i)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty result queue");

endmodule

bind scale_space_extremum_detector ssed_checker u_ssed_checker (.*);
